[hw/rtl/drs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drs_pkg
// Shared sizes and types for the disk request scheduler.
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int MAX_REQ = 64;
    localparam int IDX_W   = $clog2(MAX_REQ);
    localparam int CNT_W   = $clog2(MAX_REQ + 1);
    localparam int CYL_W   = 16;
    localparam int TOT_W   = 22;

    // Policy codes
    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_SSTF = 1'b1;

    // Input word kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    // Best-candidate state of the seek compare unit
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] best_idx;
        logic [CYL_W-1:0] best_cyl;
        logic [CYL_W-1:0] best_dist;
    } t_scan_res;

endpackage
`default_nettype wire

[hw/rtl/disk_request_scheduler.sv]
// Sequence: a load word is written to the store. A run of n requests takes n
//   serves, each passing START, SCAN (the store through one compare unit, one
//   entry per cycle), DRAIN and SERVE; an empty run gives its single word.
// Throughput: not ready while a run is in progress; loads every cycle.
// Reset: synchronous active-low; clears control, count, flags, policy to SSTF.
`default_nettype none
// ----------------------------------------------------------------------------
// disk_request_scheduler
// Stores cylinder requests and serves them in arrival or shortest-seek order.
// ----------------------------------------------------------------------------
module disk_request_scheduler (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_kind,
    input  wire logic [drs_pkg::CYL_W-1:0] i_value,
    // configuration channel
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic                      i_policy,
    // output channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic      [drs_pkg::CYL_W-1:0] o_served_cylinder,
    output logic      [drs_pkg::CYL_W-1:0] o_arm_move,
    output logic      [drs_pkg::TOT_W-1:0] o_total_move,
    output logic                           o_last,
    output logic                           o_empty_res,
    output logic                           o_overflowed
);
    import drs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_SERVE = 3'd4;
    localparam logic [2:0] ST_EMPTY = 3'd5;

    logic [2:0]         r_state, n_state;
    logic               r_policy;
    logic [CNT_W-1:0]   r_count;
    logic               r_drop;
    logic [MAX_REQ-1:0] r_done;
    logic [CYL_W-1:0]   r_head;
    logic [TOT_W-1:0]   r_total;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_served;
    logic               r_p_valid;
    logic               r_p_done;
    logic [IDX_W-1:0]   r_p_idx;
    logic               r_out_valid;

    logic               in_fire;
    logic               out_free;
    logic               st_we;
    logic [CYL_W-1:0]   rd_data;
    logic [CNT_W-1:0]   cnt_m1;
    logic [IDX_W-1:0]   last_idx;
    logic [TOT_W-1:0]   n_total;
    t_scan_res          scan_res;

    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign st_we      = in_fire && (i_kind == KIND_LOAD) && (r_count < CNT_W'(MAX_REQ));
    assign cnt_m1     = r_count - CNT_W'(1);
    assign last_idx   = cnt_m1[IDX_W-1:0];
    assign n_total    = r_total + TOT_W'(scan_res.best_dist);

    drs_store u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    drs_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clr        (r_state == ST_START),
        .i_policy     (r_policy),
        .i_head       (r_head),
        .i_cand_valid (r_p_valid && !r_p_done),
        .i_cand_idx   (r_p_idx),
        .i_cand_cyl   (rd_data),
        .o_res        (scan_res)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && (i_kind == KIND_RUN)) begin
                    n_state = (r_count == '0) ? ST_EMPTY : ST_START;
                end
            end
            ST_START: n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_idx == last_idx) n_state = ST_DRAIN;
            end
            ST_DRAIN: n_state = ST_SERVE;
            ST_SERVE: begin
                if (out_free) n_state = (r_served == last_idx) ? ST_IDLE : ST_START;
            end
            ST_EMPTY: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_policy    <= POL_SSTF;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_done      <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_policy <= i_policy;
            end
            // load words
            if (st_we) begin
                r_count <= r_count + CNT_W'(1);
            end else if (in_fire && (i_kind == KIND_LOAD)) begin
                r_drop <= 1'b1;
            end
            r_p_valid <= (r_state == ST_SCAN);
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // serve one request
            if ((r_state == ST_SERVE) && out_free) begin
                r_out_valid <= 1'b1;
                if (r_served == last_idx) begin
                    r_count <= '0;
                    r_drop  <= 1'b0;
                    r_done  <= '0;
                end else begin
                    r_done[scan_res.best_idx] <= 1'b1;
                end
            end
            // empty run
            if ((r_state == ST_EMPTY) && out_free) begin
                r_out_valid <= 1'b1;
                r_drop      <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire && (i_kind == KIND_RUN)) begin
            r_head   <= i_value;
            r_total  <= '0;
            r_served <= '0;
        end
        if (r_state == ST_START) begin
            r_idx <= '0;
        end else if (r_state == ST_SCAN) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        r_p_idx  <= r_idx;
        r_p_done <= r_done[r_idx];
        if ((r_state == ST_SERVE) && out_free) begin
            r_head            <= scan_res.best_cyl;
            r_total           <= n_total;
            r_served          <= r_served + IDX_W'(1);
            o_served_cylinder <= scan_res.best_cyl;
            o_arm_move        <= scan_res.best_dist;
            o_total_move      <= n_total;
            o_last            <= (r_served == last_idx);
            o_empty_res       <= 1'b0;
            o_overflowed      <= r_drop;
        end
        if ((r_state == ST_EMPTY) && out_free) begin
            o_served_cylinder <= '0;
            o_arm_move        <= '0;
            o_total_move      <= '0;
            o_last            <= 1'b1;
            o_empty_res       <= 1'b1;
            o_overflowed      <= r_drop;
        end
    end

    // Checks
    a_serve_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SERVE) |-> scan_res.found)
        else $error("serve without a pending request");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_REQ))
        else $error("request count beyond capacity");

    a_idle_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_done == '0))
        else $error("done flags left set outside a run");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_res) |-> (o_last && (o_total_move == '0)))
        else $error("empty run word malformed");

endmodule
`default_nettype wire

[hw/rtl/drs_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drs_store
// Request store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module drs_store (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [drs_pkg::IDX_W-1:0] i_waddr,
    input  wire logic [drs_pkg::CYL_W-1:0] i_wdata,
    input  wire logic [drs_pkg::IDX_W-1:0] i_raddr,
    output logic      [drs_pkg::CYL_W-1:0] o_rdata
);
    import drs_pkg::*;

    logic [CYL_W-1:0] r_mem [MAX_REQ];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/drs_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drs_scan
// Shared seek compare unit: one candidate per cycle, keeps the best so far.
// ----------------------------------------------------------------------------
module drs_scan (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_clr,
    input  wire logic                      i_policy,
    input  wire logic [drs_pkg::CYL_W-1:0] i_head,
    input  wire logic                      i_cand_valid,
    input  wire logic [drs_pkg::IDX_W-1:0] i_cand_idx,
    input  wire logic [drs_pkg::CYL_W-1:0] i_cand_cyl,
    output drs_pkg::t_scan_res             o_res
);
    import drs_pkg::*;

    t_scan_res        r_res;
    logic [CYL_W-1:0] cand_dist;
    logic             take;

    // Absolute distance and keep decision; ties keep the earlier entry
    always_comb begin
        cand_dist = (i_head >= i_cand_cyl) ? (i_head - i_cand_cyl) : (i_cand_cyl - i_head);
        take = i_cand_valid &&
               (!r_res.found || ((i_policy == POL_SSTF) && (cand_dist < r_res.best_dist)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_res.found <= 1'b0;
        end else if (take) begin
            r_res.found <= 1'b1;
        end
        if (take) begin
            r_res.best_idx  <= i_cand_idx;
            r_res.best_cyl  <= i_cand_cyl;
            r_res.best_dist <= cand_dist;
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire
